### hw/rtl/mks_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the Morse code table for the keying sequencer.
// No dependencies; every other file refers to this package by scoped names.
package mks_pkg;

  // Configuration register map
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_HZ = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DOT_MS  = 1'b1;

  localparam int TONE_W = 12;
  localparam int DOT_W  = 11;
  localparam int UNIT_W = 3;
  localparam int DUR_W  = 14;

  localparam logic [TONE_W-1:0] TONE_HZ_RESET = 12'd800;
  localparam logic [DOT_W-1:0]  DOT_MS_RESET  = 11'd60;

  // Segment lengths in dot units
  localparam logic [UNIT_W-1:0] UNITS_DOT      = 3'd1;
  localparam logic [UNIT_W-1:0] UNITS_DASH     = 3'd3;
  localparam logic [UNIT_W-1:0] UNITS_ELEM_GAP = 3'd1;
  localparam logic [UNIT_W-1:0] UNITS_CHAR_GAP = 3'd2;
  localparam logic [UNIT_W-1:0] UNITS_WORD_GAP = 3'd4;
  localparam logic [UNIT_W-1:0] UNITS_STOP     = 3'd7;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  // Code pattern: first element at bit 6, 1 = dash, unused bits zero
  typedef struct packed {
    logic       known;
    logic [2:0] len;
    logic [6:0] pattern;
  } morse_code_t;

  typedef struct packed {
    logic              load;       // capture the input beat
    logic              emit;       // load the output register
    logic              key;
    logic [UNIT_W-1:0] units;
    logic              stop;
    logic              last;
    logic              elem_next;  // advance to the next element
  } dp_cmd_t;

  typedef struct packed {
    logic known;
    logic is_space;
    logic end_flag;
    logic elem_dash;
    logic elem_last;
    logic slot_free;
  } dp_status_t;

  function automatic morse_code_t mk(input logic [2:0] len, input logic [6:0] pattern);
    morse_code_t r;
    r.known   = 1'b1;
    r.len     = len;
    r.pattern = pattern;
    return r;
  endfunction

  function automatic morse_code_t morse_lookup(input logic [7:0] ch);
    logic [7:0]  c;
    morse_code_t r;
    c = ch;
    if (c >= "a" && c <= "z") begin
      c = c - CASE_DELTA;
    end
    r = '0;
    case (c)
      "A": r = mk(3'd2, 7'b0100000);
      "B": r = mk(3'd4, 7'b1000000);
      "C": r = mk(3'd4, 7'b1010000);
      "D": r = mk(3'd3, 7'b1000000);
      "E": r = mk(3'd1, 7'b0000000);
      "F": r = mk(3'd4, 7'b0010000);
      "G": r = mk(3'd3, 7'b1100000);
      "H": r = mk(3'd4, 7'b0000000);
      "I": r = mk(3'd2, 7'b0000000);
      "J": r = mk(3'd4, 7'b0111000);
      "K": r = mk(3'd3, 7'b1010000);
      "L": r = mk(3'd4, 7'b0100000);
      "M": r = mk(3'd2, 7'b1100000);
      "N": r = mk(3'd2, 7'b1000000);
      "O": r = mk(3'd3, 7'b1110000);
      "P": r = mk(3'd4, 7'b0110000);
      "Q": r = mk(3'd4, 7'b1101000);
      "R": r = mk(3'd3, 7'b0100000);
      "S": r = mk(3'd3, 7'b0000000);
      "T": r = mk(3'd1, 7'b1000000);
      "U": r = mk(3'd3, 7'b0010000);
      "V": r = mk(3'd4, 7'b0001000);
      "W": r = mk(3'd3, 7'b0110000);
      "X": r = mk(3'd4, 7'b1001000);
      "Y": r = mk(3'd4, 7'b1011000);
      "Z": r = mk(3'd4, 7'b1100000);
      "0": r = mk(3'd5, 7'b1111100);
      "1": r = mk(3'd5, 7'b0111100);
      "2": r = mk(3'd5, 7'b0011100);
      "3": r = mk(3'd5, 7'b0001100);
      "4": r = mk(3'd5, 7'b0000100);
      "5": r = mk(3'd5, 7'b0000000);
      "6": r = mk(3'd5, 7'b1000000);
      "7": r = mk(3'd5, 7'b1100000);
      "8": r = mk(3'd5, 7'b1110000);
      "9": r = mk(3'd5, 7'b1111000);
      8'h22: r = mk(3'd6, 7'b0100100);  // double quote
      8'h27: r = mk(3'd6, 7'b0111100);  // apostrophe
      "$": r = mk(3'd7, 7'b0001001);
      "(": r = mk(3'd5, 7'b1011000);
      ")": r = mk(3'd6, 7'b1011010);
      "+": r = mk(3'd5, 7'b0101000);
      ",": r = mk(3'd6, 7'b1100110);
      "-": r = mk(3'd6, 7'b1000010);
      ".": r = mk(3'd6, 7'b0101010);
      "/": r = mk(3'd5, 7'b1001000);
      ":": r = mk(3'd6, 7'b1110000);
      ";": r = mk(3'd6, 7'b1010100);
      "=": r = mk(3'd5, 7'b1000100);
      "?": r = mk(3'd6, 7'b0011000);
      "_": r = mk(3'd6, 7'b0011010);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/mks_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for text input and keying segment output.
// Depends on mks_pkg for field widths.
interface mks_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       message_end;

  modport source (output valid, output character, output message_end, input ready);
  modport sink (input valid, input character, input message_end, output ready);
endinterface

interface mks_seg_if;
  logic                        valid;
  logic                        ready;
  logic                        key_down;
  logic [mks_pkg::TONE_W-1:0]  tone_out;
  logic [mks_pkg::UNIT_W-1:0]  units;
  logic [mks_pkg::DUR_W-1:0]   duration_ms;
  logic                        stops_message;
  logic                        last_in_run;

  modport source (output valid, output key_down, output tone_out, output units,
                  output duration_ms, output stops_message, output last_in_run,
                  input ready);
  modport sink (input valid, input key_down, input tone_out, input units,
                input duration_ms, input stops_message, input last_in_run,
                output ready);
endinterface

### hw/rtl/mks_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine: walks one character through its keying segments.
// Depends on mks_pkg for command and status types.
module mks_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mks_pkg::dp_status_t status,
  output mks_pkg::dp_cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_KEY    = 7'b0000100,
    S_GAP    = 7'b0001000,
    S_CGAP   = 7'b0010000,
    S_SPACE  = 7'b0100000,
    S_STOP   = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   stopped, stopped_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      stopped <= 1'b0;
    end else begin
      state   <= state_next;
      stopped <= stopped_next;
    end
  end

  always_comb begin
    state_next   = state;
    stopped_next = stopped;
    cmd          = '0;
    in_ready     = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stopped) begin
          // drop the character; the message end releases the stop
          stopped_next = !status.end_flag;
          state_next   = S_IDLE;
        end else if (status.is_space) begin
          state_next = S_SPACE;
        end else if (!status.known) begin
          stopped_next = !status.end_flag;
          state_next   = S_STOP;
        end else begin
          state_next = S_KEY;
        end
      end
      S_KEY: begin
        if (status.slot_free) begin
          cmd.emit   = 1'b1;
          cmd.key    = 1'b1;
          cmd.units  = status.elem_dash ? mks_pkg::UNITS_DASH : mks_pkg::UNITS_DOT;
          state_next = S_GAP;
        end
      end
      S_GAP: begin
        if (status.slot_free) begin
          cmd.emit  = 1'b1;
          cmd.units = mks_pkg::UNITS_ELEM_GAP;
          if (status.elem_last) begin
            state_next = S_CGAP;
          end else begin
            cmd.elem_next = 1'b1;
            state_next    = S_KEY;
          end
        end
      end
      S_CGAP: begin
        if (status.slot_free) begin
          cmd.emit   = 1'b1;
          cmd.units  = mks_pkg::UNITS_CHAR_GAP;
          cmd.last   = !status.end_flag;
          state_next = status.end_flag ? S_STOP : S_IDLE;
        end
      end
      S_SPACE: begin
        if (status.slot_free) begin
          cmd.emit   = 1'b1;
          cmd.units  = mks_pkg::UNITS_WORD_GAP;
          cmd.last   = !status.end_flag;
          state_next = status.end_flag ? S_STOP : S_IDLE;
        end
      end
      S_STOP: begin
        if (status.slot_free) begin
          cmd.emit   = 1'b1;
          cmd.units  = mks_pkg::UNITS_STOP;
          cmd.stop   = 1'b1;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/mks_datapath.sv
`timescale 1ns / 1ps
// Datapath: configuration registers, captured character code, element
// counter and the output segment register. Depends on mks_pkg and mks_if.
module mks_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mks_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mks_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic [7:0]                          character,
  input  logic                                message_end,
  input  mks_pkg::dp_cmd_t                    cmd,
  output mks_pkg::dp_status_t                 status,
  mks_seg_if.source                           seg
);

  logic [mks_pkg::TONE_W-1:0] tone_hz;
  logic [mks_pkg::DOT_W-1:0]  dot_ms;
  mks_pkg::morse_code_t       code;
  logic                       end_flag;
  logic                       is_space;
  logic [2:0]                 elem;
  logic                       out_valid;
  logic [mks_pkg::DUR_W-1:0]  duration;

  always_ff @(posedge clk) begin
    if (rst) begin
      tone_hz <= mks_pkg::TONE_HZ_RESET;
      dot_ms  <= mks_pkg::DOT_MS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mks_pkg::REG_TONE_HZ: tone_hz <= cfg_wdata;
        mks_pkg::REG_DOT_MS:  dot_ms  <= cfg_wdata[mks_pkg::DOT_W-1:0];
        default: ;
      endcase
    end
  end

  // capture the character code and walk its elements
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      code     <= mks_pkg::morse_lookup(character);
      end_flag <= message_end;
      is_space <= (character == mks_pkg::CHAR_SPACE);
      elem     <= 3'd0;
    end else if (cmd.elem_next) begin
      elem <= elem + 3'd1;
    end
  end

  assign duration = mks_pkg::DUR_W'(cmd.units) * mks_pkg::DUR_W'(dot_ms);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (seg.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      seg.key_down      <= cmd.key;
      seg.tone_out      <= cmd.key ? tone_hz : '0;
      seg.units         <= cmd.units;
      seg.duration_ms   <= duration;
      seg.stops_message <= cmd.stop;
      seg.last_in_run   <= cmd.last;
    end
  end

  assign seg.valid = out_valid;

  assign status.known     = code.known;
  assign status.is_space  = is_space;
  assign status.end_flag  = end_flag;
  assign status.elem_dash = code.pattern[3'd6 - elem];
  assign status.elem_last = (elem == code.len - 3'd1);
  assign status.slot_free = !out_valid || seg.ready;

endmodule

### hw/rtl/morse_keying_sequencer_core.sv
`timescale 1ns / 1ps
// Morse keying sequencer top level: controller plus datapath.
// Sequence: each character's beat is taken while idle and decoded, then its N segments
// (up to 16) follow, one output register load per segment, each held off while
// keying.ready stalls. A character dropped while stopped is only taken and decoded.
// Reset (rst, synchronous): idle, message running, tone 800 Hz, dot 60 ms.
module morse_keying_sequencer_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mks_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mks_pkg::CFG_DATA_W-1:0] cfg_wdata,
  mks_text_if.sink                       text,
  mks_seg_if.source                      keying
);

  // Command and status bundles between the sequencing FSM and the datapath
  mks_pkg::dp_cmd_t    cmd;
  mks_pkg::dp_status_t status;

  // The controller takes a text beat only when idle; the output register in
  // the datapath lets it do so while the previous segment still waits.
  mks_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (text.valid),
    .in_ready (text.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath holds configuration, the looked-up code, the element counter
  // and the registered output segment with its duration product.
  mks_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .character   (text.character),
    .message_end (text.message_end),
    .cmd         (cmd),
    .status      (status),
    .seg         (keying)
  );

endmodule
